// ===== design/murmur64a_hash_macros.svh =====
// assertion macros used by the checker file of the murmur64a hash block
// no dependencies; include by bare file name
`ifndef MURMUR64A_HASH_MACROS_SVH
`define MURMUR64A_HASH_MACROS_SVH

// antecedent implies consequent in the same cycle (consequent may open with a delay)
`define MM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
	else $error("assertion failed");

// antecedent implies consequent on the following cycle
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// ===== design/mm64a_pkg.sv =====
// package of the murmur64a hash block: constants, controller states and the
// command and status structs between controller and datapath; no dependencies
package mm64a_pkg;

	localparam logic [63:0] MIX_MUL    = 64'hC6A4A7935BD1E995;
	localparam int unsigned MIX_SHIFT  = 47;
	localparam logic [63:0] SEED_RESET = 64'h00000000BF114514;

	// last partial-product step of the shared multiplier
	localparam logic [1:0] MUL_STEP_LAST = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_SEED_GO,
		ST_SEED_WT,
		ST_BODY,
		ST_W1_GO,
		ST_W1_WT,
		ST_W2_GO,
		ST_W2_WT,
		ST_H_GO,
		ST_H_WT,
		ST_FIN_GO,
		ST_FIN_WT,
		ST_OUT
	} state_t;

	// multiplier operand source
	typedef enum logic [1:0] {
		MSRC_LEN,
		MSRC_WORD,
		MSRC_HASH,
		MSRC_FIN
	} msrc_t;

	// running hash update
	typedef enum logic [2:0] {
		HOP_NONE,
		HOP_SEED,
		HOP_TAIL,
		HOP_XORW,
		HOP_PROD
	} hop_t;

	typedef struct packed {
		logic  accept;
		logic  mul_start;
		msrc_t msrc;
		hop_t  hop;
		logic  w_mix;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic first;
		logic last;
		logic full;
		logic empty;
		logic out_free;
	} sts_t;

endpackage

// ===== design/mm64a_mul.sv =====
// iterative 64x64 multiply by the mix constant, low 64 bits of the product
// one 32x32 partial product per cycle; uses mm64a_pkg
module mm64a_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] operand,
	output logic        done,
	output logic [63:0] product
);

	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] pp;

	// lo*lo, then lo*hi and hi*lo into the upper half
	always_comb begin
		mul_a = x_q[31:0];
		mul_b = mm64a_pkg::MIX_MUL[31:0];
		if (step_q == 2'd1) begin
			mul_b = mm64a_pkg::MIX_MUL[63:32];
		end else if (step_q == mm64a_pkg::MUL_STEP_LAST) begin
			mul_a = x_q[63:32];
		end
	end

	assign pp = 64'(mul_a) * 64'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= busy_q && (step_q == mm64a_pkg::MUL_STEP_LAST);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == mm64a_pkg::MUL_STEP_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= operand;
		end
		if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= pp;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + pp[31:0];
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== design/mm64a_dp.sv =====
// datapath of the murmur64a hash block: item registers, running hash, seed,
// multiplier and output register; uses mm64a_pkg and mm64a_mul
module mm64a_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mm64a_pkg::cmd_t   cmd,
	output mm64a_pkg::sts_t   sts,
	input  logic              cfg_we,
	input  logic [63:0]       cfg_wdata,
	input  logic [63:0]       data_word,
	input  logic [3:0]        byte_count,
	input  logic              first_item,
	input  logic              last_item,
	input  logic [31:0]       total_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       hash_value
);

	logic [63:0] seed_q;
	logic [63:0] h_q;
	logic [63:0] w_q;
	logic [3:0]  cnt_q;
	logic        first_q;
	logic        last_q;
	logic [31:0] len_q;
	logic [63:0] out_q;
	logic        out_valid_q;
	logic [63:0] mul_op;
	logic [63:0] prod;
	logic [63:0] prod_mix;
	logic [63:0] tail_mask;
	logic        mul_done;

	mm64a_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.operand (mul_op),
		.done    (mul_done),
		.product (prod)
	);

	always_comb begin
		case (cmd.msrc)
			mm64a_pkg::MSRC_LEN:  mul_op = {32'd0, len_q};
			mm64a_pkg::MSRC_WORD: mul_op = w_q;
			mm64a_pkg::MSRC_HASH: mul_op = h_q;
			mm64a_pkg::MSRC_FIN:  mul_op = h_q ^ (h_q >> mm64a_pkg::MIX_SHIFT);
			default:              mul_op = h_q;
		endcase
	end

	assign prod_mix  = prod ^ (prod >> mm64a_pkg::MIX_SHIFT);
	assign tail_mask = (64'd1 << {cnt_q[2:0], 3'b000}) - 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= mm64a_pkg::SEED_RESET;
			h_q         <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			case (cmd.hop)
				mm64a_pkg::HOP_SEED: h_q <= seed_q ^ prod;
				mm64a_pkg::HOP_TAIL: h_q <= h_q ^ (w_q & tail_mask);
				mm64a_pkg::HOP_XORW: h_q <= h_q ^ prod;
				mm64a_pkg::HOP_PROD: h_q <= prod;
				default:             h_q <= h_q;
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			w_q     <= data_word;
			cnt_q   <= byte_count;
			first_q <= first_item;
			last_q  <= last_item;
			len_q   <= total_length;
		end else if (cmd.w_mix) begin
			w_q <= prod_mix;
		end
		if (cmd.out_load) begin
			out_q <= prod_mix;
		end
	end

	// counts of eight and above fold as a full word
	always_comb begin
		sts.mul_done = mul_done;
		sts.first    = first_q;
		sts.last     = last_q;
		sts.full     = cnt_q[3];
		sts.empty    = (cnt_q == 4'd0);
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign hash_value = out_q;

endmodule

// ===== design/mm64a_ctrl.sv =====
// controller of the murmur64a hash block: sequences the multiplies of one item
// uses mm64a_pkg
module mm64a_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mm64a_pkg::sts_t   sts,
	output mm64a_pkg::cmd_t   cmd
);

	mm64a_pkg::state_t state_q;
	mm64a_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm64a_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mm64a_pkg::ST_IDLE: begin
				if (in_valid) state_d = mm64a_pkg::ST_START;
			end
			mm64a_pkg::ST_START: begin
				state_d = sts.first ? mm64a_pkg::ST_SEED_GO : mm64a_pkg::ST_BODY;
			end
			mm64a_pkg::ST_SEED_GO: state_d = mm64a_pkg::ST_SEED_WT;
			mm64a_pkg::ST_SEED_WT: begin
				if (sts.mul_done) state_d = mm64a_pkg::ST_BODY;
			end
			mm64a_pkg::ST_BODY: begin
				if (sts.full) begin
					state_d = mm64a_pkg::ST_W1_GO;
				end else if (!sts.empty) begin
					state_d = mm64a_pkg::ST_H_GO;
				end else if (sts.last) begin
					state_d = mm64a_pkg::ST_FIN_GO;
				end else begin
					state_d = mm64a_pkg::ST_IDLE;
				end
			end
			mm64a_pkg::ST_W1_GO: state_d = mm64a_pkg::ST_W1_WT;
			mm64a_pkg::ST_W1_WT: begin
				if (sts.mul_done) state_d = mm64a_pkg::ST_W2_GO;
			end
			mm64a_pkg::ST_W2_GO: state_d = mm64a_pkg::ST_W2_WT;
			mm64a_pkg::ST_W2_WT: begin
				if (sts.mul_done) state_d = mm64a_pkg::ST_H_GO;
			end
			mm64a_pkg::ST_H_GO: state_d = mm64a_pkg::ST_H_WT;
			mm64a_pkg::ST_H_WT: begin
				if (sts.mul_done) begin
					state_d = sts.last ? mm64a_pkg::ST_FIN_GO : mm64a_pkg::ST_IDLE;
				end
			end
			mm64a_pkg::ST_FIN_GO: state_d = mm64a_pkg::ST_FIN_WT;
			mm64a_pkg::ST_FIN_WT: begin
				if (sts.mul_done) state_d = mm64a_pkg::ST_OUT;
			end
			mm64a_pkg::ST_OUT: begin
				if (sts.out_free) state_d = mm64a_pkg::ST_IDLE;
			end
			default: state_d = mm64a_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.mul_start = 1'b0;
		cmd.msrc      = mm64a_pkg::MSRC_HASH;
		cmd.hop       = mm64a_pkg::HOP_NONE;
		cmd.w_mix     = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			mm64a_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			mm64a_pkg::ST_SEED_GO: begin
				cmd.mul_start = 1'b1;
				cmd.msrc      = mm64a_pkg::MSRC_LEN;
			end
			mm64a_pkg::ST_SEED_WT: begin
				if (sts.mul_done) cmd.hop = mm64a_pkg::HOP_SEED;
			end
			mm64a_pkg::ST_BODY: begin
				if (!sts.full && !sts.empty) cmd.hop = mm64a_pkg::HOP_TAIL;
			end
			mm64a_pkg::ST_W1_GO, mm64a_pkg::ST_W2_GO: begin
				cmd.mul_start = 1'b1;
				cmd.msrc      = mm64a_pkg::MSRC_WORD;
			end
			mm64a_pkg::ST_W1_WT: begin
				cmd.w_mix = sts.mul_done;
			end
			mm64a_pkg::ST_W2_WT: begin
				if (sts.mul_done) cmd.hop = mm64a_pkg::HOP_XORW;
			end
			mm64a_pkg::ST_H_GO: begin
				cmd.mul_start = 1'b1;
				cmd.msrc      = mm64a_pkg::MSRC_HASH;
			end
			mm64a_pkg::ST_H_WT: begin
				if (sts.mul_done) cmd.hop = mm64a_pkg::HOP_PROD;
			end
			mm64a_pkg::ST_FIN_GO: begin
				cmd.mul_start = 1'b1;
				cmd.msrc      = mm64a_pkg::MSRC_FIN;
			end
			mm64a_pkg::ST_OUT: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/murmur64a_hash.sv =====
// murmur64a_hash: 64-bit word-stream hasher producing one digest per message
// every 64-bit multiply by the mix constant runs on one shared 32x32 multiplier in three
// passes; an item gets a seed multiply if first, a word premix and fold or a tail xor,
// then the hash multiply unless empty, and a finalise multiply if last; one item at a time
// reset (arst_n, asynchronous): running hash 0, seed 0xBF114514, no result pending
// depends on mm64a_pkg, mm64a_ctrl, mm64a_dp (which holds mm64a_mul)
module murmur64a_hash (
	input  logic        clk,
	input  logic        arst_n,
	// seed register write, no wait
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	// message words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first_item,
	input  logic        last_item,
	input  logic [31:0] total_length,
	// digest
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_value
);

	// command and status between sequencer and datapath
	mm64a_pkg::cmd_t cmd;
	mm64a_pkg::sts_t sts;

	// the controller walks one item through seed, word mix, tail and finalise steps;
	// it takes a new item only from its idle state
	mm64a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// the datapath holds the running hash across items, the captured item and the
	// output register, so a finished digest can wait while the next item is taken
	mm64a_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.data_word    (data_word),
		.byte_count   (byte_count),
		.first_item   (first_item),
		.last_item    (last_item),
		.total_length (total_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash_value   (hash_value)
	);

endmodule

// ===== design/mm64a_chk.sv =====
// port-level checker for murmur64a_hash, bound to the top level
// depends on murmur64a_hash_macros.svh
`include "murmur64a_hash_macros.svh"

module mm64a_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [63:0] cfg_wdata,
	input logic        in_valid,
	input logic        in_ready,
	input logic [63:0] data_word,
	input logic [3:0]  byte_count,
	input logic        first_item,
	input logic        last_item,
	input logic [31:0] total_length,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] hash_value
);

	// a stalled digest holds
	`MM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(hash_value))

	// one item at a time: ready drops after an accept
	`MM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a digest is only loaded while the block is busy
	`MM_ASSERT_IMPLY(a_out_from_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

	// an empty middle item returns to ready by way of the start and body states
	`MM_ASSERT_IMPLY(a_empty_quick, clk, arst_n, in_valid && in_ready && !first_item && !last_item && (byte_count == 4'd0), ##3 in_ready)

endmodule

bind murmur64a_hash mm64a_chk u_mm64a_chk (.*);

// ===== bench/tb_murmur64a_hash.sv =====
// self-checking testbench of murmur64a_hash: a directed table, then random messages
// under several seeds, each digest compared with a known value or an in-bench hash predictor
// depends only on the murmur64a_hash rtl
module tb_murmur64a_hash;
	timeunit 1ns;
	timeprecision 1ps;

	// hash constants of the predictor
	localparam logic [63:0] MIX_K         = 64'hC6A4A7935BD1E995;
	localparam int unsigned MIX_SH        = 47;
	localparam logic [63:0] SEED_AT_RESET = 64'h00000000BF114514;

	// longer than the slowest item, so this covers an item still in flight with no digest
	localparam int unsigned SETTLE_CYCLES = 40;
	// slowest run is about 2000 items at their slowest, each after the longest gap, plus the longest stall per digest
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned RANDOM_ITEMS  = 1850;
	localparam int unsigned SEED_PHASES   = 8;
	localparam int unsigned GAP_MAX       = 13;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        first_item;
	logic        last_item;
	logic [31:0] total_length;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] hash_value;

	murmur64a_hash uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_word    (data_word),
		.byte_count   (byte_count),
		.first_item   (first_item),
		.last_item    (last_item),
		.total_length (total_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash_value   (hash_value)
	);

	// one row of the directed table; digest is only used where known is set
	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  cnt;
		logic        first;
		logic        last;
		logic [31:0] len;
		logic        known;
		logic [63:0] digest;
	} stim_row_t;

	localparam int unsigned N_DIRECTED = 19;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// straight out of reset the running hash is zero, and zero finalises to zero
		'{64'h0, 4'd0, 1'b0, 1'b1, 32'd0, 1'b1, 64'h0},
		// empty message under the reset seed
		'{64'h0, 4'd0, 1'b1, 1'b1, 32'd0, 1'b0, 64'h0},
		// single full word, all ones then all zeros
		'{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, 64'h0},
		'{64'h0, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, 64'h0},
		// longest length field, not matching the bytes sent
		'{64'h0123456789ABCDEF, 4'd8, 1'b1, 1'b0, 32'hFFFFFFFF, 1'b0, 64'h0},
		// empty item in the middle of a message
		'{64'hFFFFFFFFFFFFFFFF, 4'd0, 1'b0, 1'b0, 32'h0, 1'b0, 64'h0},
		// byte count above eight counts as a full word
		'{64'hFEDCBA9876543210, 4'd15, 1'b0, 1'b1, 32'h0, 1'b0, 64'h0},
		// shortest and longest tails
		'{64'hFFFFFFFFFFFFFFFF, 4'd1, 1'b1, 1'b1, 32'd1, 1'b0, 64'h0},
		'{64'hFFFFFFFFFFFFFFFF, 4'd7, 1'b1, 1'b1, 32'd7, 1'b0, 64'h0},
		// tail before the end, hashing carries on
		'{64'hA5A5A5A5A5A5A5A5, 4'd3, 1'b1, 1'b0, 32'd11, 1'b0, 64'h0},
		'{64'h5A5A5A5A5A5A5A5A, 4'd8, 1'b0, 1'b1, 32'h0, 1'b0, 64'h0},
		// no first item: continues from the hash left behind
		'{64'h8000000000000001, 4'd9, 1'b0, 1'b1, 32'hFFFFFFFF, 1'b0, 64'h0},
		// a run of tails
		'{64'h00000000DEADBEEF, 4'd2, 1'b1, 1'b0, 32'd17, 1'b0, 64'h0},
		'{64'h7FFFFFFFFFFFFFFF, 4'd4, 1'b0, 1'b0, 32'h0, 1'b0, 64'h0},
		'{64'hFFFFFFFF00000000, 4'd5, 1'b0, 1'b0, 32'h0, 1'b0, 64'h0},
		'{64'h1122334455667788, 4'd6, 1'b0, 1'b1, 32'h0, 1'b0, 64'h0},
		// neither flag, no digest expected
		'{64'hC3C3C3C3C3C3C3C3, 4'd12, 1'b0, 1'b0, 32'h12345678, 1'b0, 64'h0},
		'{64'h0, 4'd0, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b0, 64'h0},
		'{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1, 1'b1, 32'd0, 1'b0, 64'h0}
	};

	typedef struct {
		logic [63:0] digest;
		int unsigned item_no;
	} digest_exp_t;

	digest_exp_t digest_q[$];

	// predictor state, mirrors the seed register and the running hash
	logic [63:0] seed_shadow;
	logic [63:0] chain_hash;

	int unsigned items_sent = 0;
	int unsigned mismatch_count = 0;
	logic        send_burst = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// cycle counter as a last resort against a hung handshake
	initial begin : watchdog
		int unsigned cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("tb_murmur64a_hash NOT OK");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// full word: premix the word, fold it in, multiply
	function automatic logic [63:0] absorb_word(input logic [63:0] h, input logic [63:0] w);
		logic [63:0] k;
		k = w * MIX_K;
		k = k ^ (k >> MIX_SH);
		k = k * MIX_K;
		return (h ^ k) * MIX_K;
	endfunction

	// partial word: xor the low bytes only, then multiply
	function automatic logic [63:0] absorb_tail(input logic [63:0] h, input logic [63:0] w,
		input int unsigned nbytes);
		logic [63:0] mask;
		mask = (64'd1 << (8 * nbytes)) - 64'd1;
		return (h ^ (w & mask)) * MIX_K;
	endfunction

	function automatic logic [63:0] avalanche(input logic [63:0] h);
		logic [63:0] f;
		f = h ^ (h >> MIX_SH);
		f = f * MIX_K;
		return f ^ (f >> MIX_SH);
	endfunction

	// advances the predicted hash by one item, gives the digest when the item ends a message
	task automatic predict_item(input logic [63:0] word, input logic [3:0] cnt,
		input logic first, input logic last, input logic [31:0] len,
		output logic makes_digest, output logic [63:0] digest);
		logic [63:0] h;
		h = chain_hash;
		if (first)
			h = seed_shadow ^ ({32'd0, len} * MIX_K);
		if (cnt >= 4'd8)
			h = absorb_word(h, word);
		else if (cnt != 4'd0)
			h = absorb_tail(h, word, cnt);
		chain_hash = h;
		makes_digest = last;
		digest = avalanche(h);
	endtask

	// offers one item after a random gap, entered and left at a falling edge
	task automatic push_item(input logic [63:0] word, input logic [3:0] cnt,
		input logic first, input logic last, input logic [31:0] len,
		input logic known, input logic [63:0] known_digest);
		int unsigned gap;
		logic        makes_digest;
		logic [63:0] digest;
		digest_exp_t pending;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		data_word    <= word;
		byte_count   <= cnt;
		first_item   <= first;
		last_item    <= last;
		total_length <= len;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// accepted on this edge
		predict_item(word, cnt, first, last, len, makes_digest, digest);
		if (makes_digest) begin
			pending.digest  = known ? known_digest : digest;
			pending.item_no = items_sent;
			digest_q.push_back(pending);
		end
		items_sent++;
		@(negedge clk);
	endtask

	// drops valid and waits for every digest, then lets any digest-less item finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		seed_shadow = value;
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 15))
			0:       return 64'h0;
			1:       return 64'hFFFFFFFFFFFFFFFF;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// one well-formed message of random length, now and then cut short or with a wrong length
	task automatic send_message();
		int unsigned sel;
		int unsigned nbytes;
		int unsigned nwords;
		int unsigned i;
		logic [31:0] len_field;
		logic [3:0]  cnt;
		logic        truncate;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			nbytes = $urandom_range(0, 24);
		else if (sel < 95)
			nbytes = $urandom_range(25, 64);
		else
			nbytes = $urandom_range(65, 200);
		nwords    = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
		len_field = ($urandom_range(0, 9) == 0) ? $urandom : nbytes;
		truncate  = (nwords > 1) && ($urandom_range(0, 19) == 0);
		for (i = 0; i < nwords; i++) begin
			if (truncate && i == nwords - 1)
				break;
			if (nbytes == 0)
				cnt = 4'd0;
			else if (i < nwords - 1 || nbytes % 8 == 0)
				cnt = 4'd8;
			else
				cnt = 4'(nbytes % 8);
			// oversized counts still mean a full word
			if (cnt == 4'd8 && $urandom_range(0, 15) == 0)
				cnt = 4'($urandom_range(9, 15));
			push_item(rand_word(), cnt, i == 0, i == nwords - 1,
				(i == 0) ? len_field : $urandom, 1'b0, 64'h0);
		end
	endtask

	// digest side: random stalls, compares each digest with the oldest expectation
	initial begin : collect_digests
		int unsigned stall;
		logic        recv_burst;
		digest_exp_t head;
		recv_burst = 1'b0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_burst = !recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (digest_q.size() == 0) begin
				flag_mismatch($sformatf("digest %h with none expected", hash_value));
			end else begin
				head = digest_q.pop_front();
				if (hash_value !== head.digest)
					flag_mismatch($sformatf("item %0d: digest %h, expected %h",
						head.item_no, hash_value, head.digest));
			end
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int unsigned row;
		int unsigned phase;
		int unsigned target;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 64'h0;
		in_valid     = 1'b0;
		data_word    = 64'h0;
		byte_count   = 4'd0;
		first_item   = 1'b0;
		last_item    = 1'b0;
		total_length = 32'd0;
		seed_shadow  = SEED_AT_RESET;
		chain_hash   = 64'h0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table under the reset seed
		for (row = 0; row < N_DIRECTED; row++)
			push_item(DIRECTED_ROWS[row].word, DIRECTED_ROWS[row].cnt,
				DIRECTED_ROWS[row].first, DIRECTED_ROWS[row].last,
				DIRECTED_ROWS[row].len, DIRECTED_ROWS[row].known,
				DIRECTED_ROWS[row].digest);
		// full pause until every digest is back
		wait_idle();

		// random part, one seed per phase, extremes first
		for (phase = 1; phase <= SEED_PHASES; phase++) begin
			case (phase)
				1:       write_seed(64'h0);
				2:       write_seed(64'hFFFFFFFFFFFFFFFF);
				default: write_seed({$urandom, $urandom});
			endcase
			target = N_DIRECTED + RANDOM_ITEMS * phase / SEED_PHASES;
			while (items_sent < target) begin
				// mostly real messages, some loose items with random flags and counts
				if ($urandom_range(0, 99) < 12)
					push_item(rand_word(), 4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						$urandom, 1'b0, 64'h0);
				else
					send_message();
			end
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("tb_murmur64a_hash OK");
		else
			$display("tb_murmur64a_hash NOT OK");
		$finish;
	end

endmodule
